>>> hw/rtl/tml_pkg.sv
package tml_pkg;

  // Widths fixed by the configuration and result fields
  localparam int CFG_BITS       = 16;
  localparam int LEVEL_BITS     = 10;
  localparam int CFG_INDEX_BITS = 1;

  // Default sizes of the sample window
  localparam int WINDOW_DEPTH_DEFAULT = 8;
  localparam int SAMPLE_BITS_DEFAULT  = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_EMPTY_MV = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_MV  = 1'b1;

  // Reset values of the calibration registers
  localparam logic [CFG_BITS-1:0] EMPTY_MV_RESET = 16'd0;
  localparam logic [CFG_BITS-1:0] FULL_MV_RESET  = 16'd10000;

  // Item kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_PUBLISH = 1'b1;

  // Trim one minimum and one maximum from this many samples on
  localparam int TRIM_MIN_COUNT = 5;

  // Full tank in tenths of a percent
  localparam int LEVEL_FULL_SCALE = 1000;

endpackage

>>> hw/rtl/trimmed_mean_tank_level.sv
// Tank level from a trimmed moving mean of sensor voltages.
//
// Input channel (in_valid/in_ready, kind, sample_mv): kind 0 stores
// sample_mv into a ring of WINDOW_DEPTH entries; kind 1 asks for a level.
// A request on an empty ring is dropped without a result.
// Output channel (out_valid/out_ready, level_tenth_pct, average_mv): one
// transaction per request on a non-empty ring, in request order.
// Configuration: cfg_write with cfg_index 0 (empty_mv) or 1 (full_mv) and
// cfg_data; takes effect at once, write only while idle.
//
// Timing: a sample is written into the ring as it is accepted. A request walks
// the ring through the registered read port, then runs two divisions on one
// shared restoring divider, one quotient bit per cycle over DVD_W bits, the
// larger of max(SAMPLE_BITS,16) + 10 and SAMPLE_BITS plus the fill count width.
// Clamped levels skip the second division. in_ready is low while a request
// is worked on and rises with out_valid.
// A finished result sits in the output register; while it waits the block
// takes new samples, and a second request holds at its end until out_ready.
// Reset (rst, synchronous) empties the ring, clears the result and loads
// empty_mv = 0, full_mv = 10000.
module trimmed_mean_tank_level #(
  parameter int WINDOW_DEPTH = tml_pkg::WINDOW_DEPTH_DEFAULT,
  parameter int SAMPLE_BITS  = tml_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic [SAMPLE_BITS-1:0]             sample_mv,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tml_pkg::LEVEL_BITS-1:0]     level_tenth_pct,
  output logic [SAMPLE_BITS-1:0]             average_mv,
  input  logic                               cfg_write,
  input  logic [tml_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tml_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int IDX_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
  localparam int CMP_W    = (SAMPLE_BITS > tml_pkg::CFG_BITS) ? SAMPLE_BITS
                                                              : tml_pkg::CFG_BITS;
  localparam int PROD_W   = CMP_W + tml_pkg::LEVEL_BITS;
  localparam int DVD_W    = (PROD_W > SUM_BITS) ? PROD_W : SUM_BITS;
  localparam int DVS_W    = (tml_pkg::CFG_BITS > CNT_BITS) ? tml_pkg::CFG_BITS
                                                           : CNT_BITS;

  // Sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SWEEP     = 4'd1;
  localparam logic [3:0] S_TRIM      = 4'd2;
  localparam logic [3:0] S_START_AVG = 4'd3;
  localparam logic [3:0] S_WAIT_AVG  = 4'd4;
  localparam logic [3:0] S_SCALE     = 4'd5;
  localparam logic [3:0] S_MUL       = 4'd6;
  localparam logic [3:0] S_START_LVL = 4'd7;
  localparam logic [3:0] S_WAIT_LVL  = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [IDX_BITS-1:0]          write_slot;
  logic [CNT_BITS-1:0]          fill_count;
  logic [tml_pkg::CFG_BITS-1:0] empty_mv;
  logic [tml_pkg::CFG_BITS-1:0] full_mv;
  logic [CNT_BITS-1:0]          rd_idx;
  logic                         rd_pend;
  logic                         first;
  logic [SUM_BITS-1:0]          sum;
  logic [SAMPLE_BITS-1:0]       lo;
  logic [SAMPLE_BITS-1:0]       hi;
  logic [CNT_BITS-1:0]          count;
  logic [SAMPLE_BITS-1:0]       avg;
  logic [CMP_W-1:0]             diff;
  logic [CMP_W-1:0]             span;
  logic [DVD_W-1:0]             prod;
  logic [tml_pkg::LEVEL_BITS-1:0] level;

  logic                   in_accept;
  logic                   ring_we;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_issue;
  logic                   div_start;
  logic [DVD_W-1:0]       div_dividend;
  logic [DVS_W-1:0]       div_divisor;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quotient;
  logic [CMP_W-1:0]       avg_ext;
  logic [CMP_W-1:0]       empty_ext;
  logic [CMP_W-1:0]       full_ext;
  logic                   load_out;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign ring_we   = in_accept && (kind == tml_pkg::KIND_SAMPLE);
  assign rd_issue  = (rd_idx != fill_count);
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  assign avg_ext   = CMP_W'(avg);
  assign empty_ext = CMP_W'(empty_mv);
  assign full_ext  = CMP_W'(full_mv);

  // Sample ring
  tml_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (sample_mv),
    .raddr (rd_idx[IDX_BITS-1:0]),
    .rdata (rd_data)
  );

  // Shared divider: first the mean, then the scaled level unless it is clamped
  assign div_start    = (state == S_START_AVG) || (state == S_START_LVL);
  assign div_dividend = (state == S_START_AVG) ? DVD_W'(sum) : prod;
  assign div_divisor  = (state == S_START_AVG) ? DVS_W'(count) : DVS_W'(span);

  tml_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_mv <= tml_pkg::EMPTY_MV_RESET;
      full_mv  <= tml_pkg::FULL_MV_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tml_pkg::CFG_EMPTY_MV: empty_mv <= cfg_data;
        tml_pkg::CFG_FULL_MV:  full_mv  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the write slot and the saturating fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (ring_we) begin
      if (write_slot == IDX_BITS'(WINDOW_DEPTH - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
      if (fill_count != CNT_BITS'(WINDOW_DEPTH)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && kind == tml_pkg::KIND_PUBLISH && fill_count != '0) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (!rd_issue && !rd_pend) begin
          state_next = S_TRIM;
        end
      end
      S_TRIM:      state_next = S_START_AVG;
      S_START_AVG: state_next = S_WAIT_AVG;
      S_WAIT_AVG: begin
        if (div_done) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        if (full_mv <= empty_mv || avg_ext <= empty_ext || avg_ext >= full_ext) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL:       state_next = S_START_LVL;
      S_START_LVL: state_next = S_WAIT_LVL;
      S_WAIT_LVL: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sweep control: issue one read per cycle, data returns in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
      first   <= 1'b0;
    end else if (state == S_IDLE) begin
      rd_idx  <= '0;
      rd_pend <= 1'b0;
      first   <= 1'b1;
    end else if (state == S_SWEEP) begin
      rd_pend <= rd_issue;
      if (rd_issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_pend) begin
        first <= 1'b0;
      end
    end
  end

  // Datapath: accumulate, trim, scale
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sum <= '0;
      end
      S_SWEEP: begin
        if (rd_pend) begin
          sum <= sum + SUM_BITS'(rd_data);
          if (first || rd_data < lo) begin
            lo <= rd_data;
          end
          if (first || rd_data > hi) begin
            hi <= rd_data;
          end
        end
      end
      S_TRIM: begin
        if (fill_count >= CNT_BITS'(tml_pkg::TRIM_MIN_COUNT)) begin
          sum   <= sum - (SUM_BITS'(lo) + SUM_BITS'(hi));
          count <= fill_count - CNT_BITS'(2);
        end else begin
          count <= fill_count;
        end
      end
      S_WAIT_AVG: begin
        if (div_done) begin
          avg <= div_quotient[SAMPLE_BITS-1:0];
        end
      end
      S_SCALE: begin
        diff <= avg_ext - empty_ext;
        if (full_mv <= empty_mv || avg_ext <= empty_ext) begin
          level <= '0;
        end else begin
          level <= tml_pkg::LEVEL_BITS'(tml_pkg::LEVEL_FULL_SCALE);
        end
      end
      S_MUL: begin
        prod <= DVD_W'(diff) * DVD_W'(tml_pkg::LEVEL_FULL_SCALE);
        span <= full_ext - empty_ext;
      end
      S_WAIT_LVL: begin
        if (div_done) begin
          level <= div_quotient[tml_pkg::LEVEL_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      level_tenth_pct <= level;
      average_mv      <= avg;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level_tenth_pct <= tml_pkg::LEVEL_BITS'(tml_pkg::LEVEL_FULL_SCALE))
    else $error("level beyond full scale");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_BITS'(WINDOW_DEPTH) && write_slot <= IDX_BITS'(WINDOW_DEPTH - 1))
    else $error("ring pointers out of range");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WAIT_AVG || state == S_WAIT_LVL))
    else $error("divider finished outside a wait state");

endmodule

>>> hw/rtl/tml_ram.sv
module tml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tml_div.sv
module tml_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              run_q;
  logic              done_q;
  logic [DVS_W:0]    partial;
  logic [DVS_W:0]    trial;
  logic              fits;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    partial = {rem_q, dvd_q[DVD_W-1]};
    fits    = (partial >= {1'b0, dvs_q});
    trial   = partial - {1'b0, dvs_q};
  end

  // Control: run for one step per quotient bit, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(DVD_W);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring division, quotient shifts into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_q <= dividend;
      rem_q <= '0;
      dvs_q <= divisor;
    end else if (run_q) begin
      if (fits) begin
        rem_q <= trial[DVS_W-1:0];
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= partial[DVS_W-1:0];
        dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_q;
  assign quotient = dvd_q;

  // The sequencer never restarts a division in flight
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !run_q)
    else $error("division started while busy");

  // The last step always produces the done pulse
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (run_q && !start && step_q == STEP_W'(1)) |=> done_q)
    else $error("division finished without done");

endmodule

>>> dv/tb_trimmed_mean_tank_level.sv
module tb_trimmed_mean_tank_level;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW      = tml_pkg::WINDOW_DEPTH_DEFAULT;
  localparam int MV_BITS     = tml_pkg::SAMPLE_BITS_DEFAULT;
  localparam int LVL_BITS    = tml_pkg::LEVEL_BITS;
  localparam int IDX_BITS    = tml_pkg::CFG_INDEX_BITS;
  localparam int REG_BITS    = tml_pkg::CFG_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 100;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic               kind;
    logic [MV_BITS-1:0] mv;
  } sensor_item_t;

  typedef struct packed {
    logic [LVL_BITS-1:0] level;
    logic [MV_BITS-1:0]  avg_mv;
  } tank_reading_t;

  // Block ports
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      kind = tml_pkg::KIND_SAMPLE;
  logic [MV_BITS-1:0]        sample_mv = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [LVL_BITS-1:0]       level_tenth_pct;
  logic [MV_BITS-1:0]        average_mv;
  logic                      cfg_write = 1'b0;
  logic [IDX_BITS-1:0]       cfg_index = tml_pkg::CFG_EMPTY_MV;
  logic [REG_BITS-1:0]       cfg_data = '0;

  // Sensor items waiting for the driver, and readings still owed by the block
  sensor_item_t  sensor_items[$];
  tank_reading_t readings_due[$];
  sensor_item_t  next_item;

  // Shadow of the block state and calibration
  logic [MV_BITS-1:0]  ring_mv [WINDOW];
  int                  ring_slot = 0;
  int                  ring_fill = 0;
  logic [REG_BITS-1:0] cal_empty = tml_pkg::EMPTY_MV_RESET;
  logic [REG_BITS-1:0] cal_full = tml_pkg::FULL_MV_RESET;

  // Bookkeeping
  int  items_offered = 0;
  int  items_accepted = 0;
  int  samples_seen = 0;
  int  requests_seen = 0;
  int  readings_checked = 0;
  int  settings_run = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  ready_hold = 0;
  int  long_holds_asked = 0;
  int  long_holds_done = 0;
  bit  calm_finish = 1'b0;
  bit  in_fire = 1'b0;
  logic [MV_BITS-1:0] last_mv = '0;

  trimmed_mean_tank_level dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .sample_mv       (sample_mv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .level_tenth_pct (level_tenth_pct),
    .average_mv      (average_mv),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Store a sample or work out the level reading a request should produce
  task automatic compute_tank_reading(input logic item_kind, input logic [MV_BITS-1:0] mv);
    longint unsigned sum, lo, hi, cnt, avg, lvl, span;
    tank_reading_t   reading;
    if (item_kind == tml_pkg::KIND_SAMPLE) begin
      ring_mv[ring_slot] = mv;
      ring_slot = (ring_slot + 1) % WINDOW;
      if (ring_fill < WINDOW) ring_fill++;
      samples_seen++;
    end else begin
      requests_seen++;
      if (ring_fill != 0) begin
        sum = 0;
        lo = ring_mv[0];
        hi = ring_mv[0];
        for (int i = 0; i < ring_fill; i++) begin
          sum += ring_mv[i];
          if (ring_mv[i] < lo) lo = ring_mv[i];
          if (ring_mv[i] > hi) hi = ring_mv[i];
        end
        cnt = ring_fill;
        // Drop one minimum and one maximum once the window is deep enough
        if (cnt >= tml_pkg::TRIM_MIN_COUNT) begin
          sum -= lo + hi;
          cnt -= 2;
        end
        avg = sum / cnt;
        // Map linearly onto the calibration span and clamp
        if (cal_full <= cal_empty || avg <= cal_empty) lvl = 0;
        else if (avg >= cal_full) lvl = tml_pkg::LEVEL_FULL_SCALE;
        else begin
          span = cal_full - cal_empty;
          lvl = ((avg - cal_empty) * tml_pkg::LEVEL_FULL_SCALE) / span;
        end
        reading.level = lvl[LVL_BITS-1:0];
        reading.avg_mv = avg[MV_BITS-1:0];
        readings_due = {readings_due, reading};
      end
    end
  endtask

  task automatic report_mismatch(input string what, input tank_reading_t want,
                                 input tank_reading_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected level %0d avg %0d mV, got level %0d avg %0d mV",
               $realtime, what, want.level, want.avg_mv, got.level, got.avg_mv);
  endtask

  // Sample both channels at the rising edge; check results, then predict
  always @(posedge clk) begin
    tank_reading_t got;
    tank_reading_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got.level = level_tenth_pct;
        got.avg_mv = average_mv;
        if (readings_due.size() == 0) begin
          want = '0;
          report_mismatch("result with none outstanding", want, got);
        end else begin
          want = readings_due.pop_front();
          readings_checked++;
          if (got.level != want.level || got.avg_mv != want.avg_mv)
            report_mismatch("reading mismatch", want, got);
        end
      end
      if (in_valid && in_ready) begin
        items_accepted++;
        compute_tank_reading(kind, sample_mv);
      end
    end
  end

  // Drive the input channel from the item queue, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_fire && !calm_finish && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 9);
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sensor_items.size() > 0) begin
          next_item = sensor_items.pop_front();
          in_valid <= 1'b1;
          kind <= next_item.kind;
          sample_mv <= next_item.mv;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Drive out_ready: short random holds, and a long one on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_holds_done != long_holds_asked) begin
      long_holds_done++;
      ready_hold = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (!calm_finish && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d readings outstanding",
               $realtime, idle_cycles, readings_due.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer(input logic item_kind, input logic [MV_BITS-1:0] mv);
    sensor_item_t item;
    item.kind = item_kind;
    item.mv = mv;
    sensor_items = {sensor_items, item};
    items_offered++;
  endtask

  // Hold until every item is taken and every reading has come, then settle
  task automatic wait_drained();
    do @(negedge clk);
    while (items_accepted != items_offered || readings_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(input logic [IDX_BITS-1:0] idx,
                                input logic [REG_BITS-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == tml_pkg::CFG_EMPTY_MV) cal_empty = value;
    else cal_full = value;
  endtask

  // Random samples mostly around the calibration span, some anywhere, mixed with level requests
  task automatic queue_random_items(input int count);
    int lo, hi;
    logic [MV_BITS-1:0] mv;
    lo = (cal_empty < cal_full) ? cal_empty : cal_full;
    hi = (cal_empty < cal_full) ? cal_full : cal_empty;
    lo = (lo > 500) ? lo - 500 : 0;
    hi = (hi < 65035) ? hi + 500 : 65535;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: mv = MV_BITS'($urandom_range(hi, lo));
        5, 6, 7:       mv = MV_BITS'($urandom());
        8:             mv = $urandom_range(0, 1) ? '1 : '0;
        default:       mv = last_mv;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        offer(tml_pkg::KIND_PUBLISH, MV_BITS'($urandom()));
      end else begin
        offer(tml_pkg::KIND_SAMPLE, mv);
        last_mv = mv;
      end
    end
  endtask

  task automatic run_setting(input logic [REG_BITS-1:0] empty_val,
                             input logic [REG_BITS-1:0] full_val,
                             input int count, input bit with_long_hold);
    write_register(tml_pkg::CFG_EMPTY_MV, empty_val);
    write_register(tml_pkg::CFG_FULL_MV, full_val);
    settings_run++;
    queue_random_items(count);
    if (with_long_hold) long_holds_asked++;
    wait_drained();
  endtask

  initial begin
    int e, f;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: empty ring, extremes, fill depths one to five and full, wrap of the ring
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    offer(tml_pkg::KIND_SAMPLE, 16'd0);
    offer(tml_pkg::KIND_PUBLISH, 16'hFFFF);
    offer(tml_pkg::KIND_SAMPLE, 16'hFFFF);
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    offer(tml_pkg::KIND_SAMPLE, 16'd5000);
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    offer(tml_pkg::KIND_SAMPLE, 16'd2500);
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    offer(tml_pkg::KIND_SAMPLE, 16'd7777);
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    offer(tml_pkg::KIND_SAMPLE, 16'h5555);
    offer(tml_pkg::KIND_SAMPLE, 16'hAAAA);
    offer(tml_pkg::KIND_SAMPLE, 16'd10000);
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    offer(tml_pkg::KIND_SAMPLE, 16'd4000);
    offer(tml_pkg::KIND_SAMPLE, 16'd4001);
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    offer(tml_pkg::KIND_SAMPLE, 16'd9999);
    offer(tml_pkg::KIND_PUBLISH, 16'd0);
    settings_run++;
    wait_drained();

    // Random phases over a spread of calibrations, extremes included
    run_setting(16'd1000, 16'd9000, 110, 1'b0);
    run_setting(16'd0, 16'hFFFF, 110, 1'b1);
    run_setting(16'd40000, 16'd20000, 90, 1'b0);
    run_setting(16'd12345, 16'd12345, 80, 1'b0);
    run_setting(16'hFFFF, 16'hFFFF, 60, 1'b0);
    run_setting(16'd0, 16'd0, 60, 1'b0);
    run_setting(16'hFFFE, 16'hFFFF, 80, 1'b0);
    repeat (3) begin
      e = $urandom_range(0, 60000);
      f = e + $urandom_range(1, 65535 - e);
      run_setting(e[REG_BITS-1:0], f[REG_BITS-1:0], 100, 1'b0);
    end

    // Finish at full rate on the reset calibration
    calm_finish = 1'b1;
    run_setting(tml_pkg::EMPTY_MV_RESET, tml_pkg::FULL_MV_RESET, 160, 1'b0);

    $display("Covered %0d samples and %0d level requests; %0d readings checked",
             samples_seen, requests_seen, readings_checked);
    $display("across %0d calibration settings, with %0d mismatches",
             settings_run, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tml_pkg.sv
hw/rtl/tml_ram.sv
hw/rtl/tml_div.sv
hw/rtl/trimmed_mean_tank_level.sv
dv/tb_trimmed_mean_tank_level.sv
